// ===== rtl/core/bbp_pkg.sv =====
// Shared constants, codes and types of the bimodal branch predictor with target buffer.
package bbp_pkg;

   localparam int BBP_TABLE_ENTRIES = 1024;
   localparam int BBP_PC_WIDTH      = 64;
   localparam int QUEUE_DEPTH       = 2;

   localparam int FW_W        = 5;
   localparam int IB_W        = 4;
   localparam int SLOT_W      = 5;
   localparam int CTR_W       = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_FETCH_WIDTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INST_BYTES  = 1'b1;

   localparam logic [FW_W-1:0] FETCH_WIDTH_RST = 5'd4;
   localparam logic [IB_W-1:0] INST_BYTES_RST  = 4'd4;

   localparam logic CMD_PREDICT = 1'b0;
   localparam logic CMD_UPDATE  = 1'b1;

   localparam logic [CTR_W-1:0] CTR_MAX  = 2'd3;
   localparam logic [CTR_W-1:0] CTR_INIT = 2'd1;
   localparam logic [CTR_W-1:0] CTR_MIN  = 2'd0;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } bbp_state_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } bbp_back_stat_type;

endpackage

// ===== rtl/core/bbp_front.sv =====
// Front end: accepts items and holds them in a short queue for the back end.
module bbp_front
   import bbp_pkg::*;
#(
   parameter int PC_WIDTH = BBP_PC_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_cmd,
   input  logic [PC_WIDTH-1:0]   req_pkt_pc,
   input  logic [SLOT_W-1:0]     req_resolved_slot,
   input  logic                  req_was_taken,
   input  logic [PC_WIDTH-1:0]   req_resolved_target,
   input  bbp_back_stat_type     stat,
   output logic                  q_valid,
   output logic [2*PC_WIDTH+6:0] q_item
);

   localparam int ITEM_W = 2 * PC_WIDTH + 7;
   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

   logic [ITEM_W-1:0] entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              accept;

   assign busy    = stat.clearing || (count_ff == CNT_W'(QUEUE_DEPTH));
   assign accept  = start && !busy;
   assign q_valid = (count_ff != '0);
   assign q_item  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (stat.pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (accept && !stat.pop) begin
         count_in = count_ff + 1'b1;
      end else if (!accept && stat.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entries_ff[wr_ptr_ff] <= {req_cmd, req_pkt_pc, req_resolved_slot,
                                   req_was_taken, req_resolved_target};
      end
   end

endmodule

// ===== rtl/core/bbp_back.sv =====
// Back end: predictor table, clearing pass, lookup, training and result registers.
module bbp_back
   import bbp_pkg::*;
#(
   parameter int TABLE_ENTRIES = BBP_TABLE_ENTRIES,
   parameter int PC_WIDTH      = BBP_PC_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  logic [2*PC_WIDTH+6:0] q_item,
   output bbp_back_stat_type     stat,
   input  logic [FW_W-1:0]       fetch_width,
   input  logic [IB_W-1:0]       inst_bytes,
   output logic                  rsp_strobe,
   output logic [PC_WIDTH-1:0]   rsp_next_pc,
   output logic [SLOT_W-1:0]     rsp_pred_slot,
   output logic                  rsp_hit,
   output logic                  rsp_update_miss
);

   // Indexed by low PC bits; keep the depth a power of two, as nothing checks it.
   localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int ITEM_W  = 2 * PC_WIDTH + 7;
   localparam int ENTRY_W = 2 * PC_WIDTH + 8;
   localparam int FT_W    = SLOT_W + 1 + IB_W;
   localparam int MS_W    = FW_W + IB_W;

   logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];

   bbp_state_type     state_ff, state_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic [ITEM_W-1:0] item_ff;
   logic [ENTRY_W-1:0] rd_ff;
   logic              exec;

   logic                rsp_strobe_ff;
   logic [PC_WIDTH-1:0] rsp_next_pc_ff;
   logic [SLOT_W-1:0]   rsp_pred_slot_ff;
   logic                rsp_hit_ff;
   logic                rsp_update_miss_ff;

   logic                it_cmd;
   logic [PC_WIDTH-1:0] it_pc;
   logic [SLOT_W-1:0]   it_slot;
   logic                it_taken;
   logic [PC_WIDTH-1:0] it_target;

   logic                e_valid;
   logic [PC_WIDTH-1:0] e_tag;
   logic [CTR_W-1:0]    e_ctr;
   logic [SLOT_W-1:0]   e_slot;
   logic [PC_WIDTH-1:0] e_target;

   logic                hit;
   logic [SLOT_W:0]     slot_inc;
   logic [FT_W-1:0]     ft_mul;
   logic [MS_W-1:0]     miss_mul;
   logic [PC_WIDTH-1:0] hit_next;
   logic [PC_WIDTH-1:0] miss_next;
   logic [CTR_W-1:0]    ctr_upd;

   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [ENTRY_W-1:0]  mem_wdata;
   logic [IDX_W-1:0]    mem_raddr;

   assign it_cmd    = item_ff[ITEM_W-1];
   assign it_pc     = item_ff[ITEM_W-2 -: PC_WIDTH];
   assign it_slot   = item_ff[PC_WIDTH+SLOT_W -: SLOT_W];
   assign it_taken  = item_ff[PC_WIDTH];
   assign it_target = item_ff[PC_WIDTH-1:0];

   assign e_valid  = rd_ff[ENTRY_W-1];
   assign e_tag    = rd_ff[ENTRY_W-2 -: PC_WIDTH];
   assign e_ctr    = rd_ff[PC_WIDTH+SLOT_W+CTR_W-1 -: CTR_W];
   assign e_slot   = rd_ff[PC_WIDTH+SLOT_W-1 -: SLOT_W];
   assign e_target = rd_ff[PC_WIDTH-1:0];

   assign mem_raddr = q_item[PC_WIDTH+SLOT_W+1 +: IDX_W];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      stat.pop      = 1'b0;
      stat.clearing = 1'b0;
      exec          = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            stat.clearing = 1'b1;
         end
         ST_IDLE: begin
            stat.pop = q_valid;
         end
         ST_EXEC: begin
            exec = 1'b1;
         end
         default: begin
            stat.clearing = 1'b0;
         end
      endcase
   end

   assign clr_in = stat.clearing ? clr_ff + 1'b1 : clr_ff;

   assign hit       = e_valid && (e_tag == it_pc);
   assign slot_inc  = {1'b0, e_slot} + 1'b1;
   assign ft_mul    = FT_W'(slot_inc) * FT_W'(inst_bytes);
   assign miss_mul  = MS_W'(fetch_width) * MS_W'(inst_bytes);
   assign hit_next  = (e_ctr > CTR_INIT) ? e_target : it_pc + PC_WIDTH'(ft_mul);
   assign miss_next = it_pc + PC_WIDTH'(miss_mul);

   always_comb begin
      if (it_taken) begin
         ctr_upd = (e_ctr == CTR_MAX) ? CTR_MAX : e_ctr + 1'b1;
      end else begin
         ctr_upd = (e_ctr == CTR_MIN) ? CTR_MIN : e_ctr - 1'b1;
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = it_pc[IDX_W-1:0];
      mem_wdata = {1'b1, e_tag, ctr_upd, it_slot, it_taken ? it_target : e_target};
      if (stat.clearing) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (exec) begin
         if (it_cmd == CMD_PREDICT) begin
            mem_we    = !hit;
            mem_wdata = {1'b1, it_pc, CTR_INIT, fetch_width, miss_next};
         end else begin
            mem_we = hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (stat.pop) begin
         item_ff <= q_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= exec;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_hit_ff <= hit;
         if (it_cmd == CMD_PREDICT) begin
            rsp_next_pc_ff     <= hit ? hit_next : miss_next;
            rsp_pred_slot_ff   <= hit ? e_slot : fetch_width;
            rsp_update_miss_ff <= 1'b0;
         end else begin
            rsp_next_pc_ff     <= '0;
            rsp_pred_slot_ff   <= '0;
            rsp_update_miss_ff <= !hit;
         end
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_next_pc     = rsp_next_pc_ff;
   assign rsp_pred_slot   = rsp_pred_slot_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_update_miss = rsp_update_miss_ff;

endmodule

// ===== rtl/core/bimodal_branch_predictor_btb_top.sv =====
// Top level of the bimodal branch predictor with branch target buffer.
//
// An item is offered on the req_ ports with start and is taken at a clock edge
// where start is high and busy is low. A predict item (req_cmd low) looks up
// req_pkt_pc and returns the predicted next PC and branch slot; an update
// item (req_cmd high) trains the matching entry or reports an update miss.
// Each item gives one result, shown on the rsp_ ports for one cycle with
// rsp_strobe high; the receiver cannot hold results off.
// An accepted item passes from the queue into the item and table read registers,
// then into the result registers. The back end serves one item at a time with its
// idle and exec states, and takes no new item from the queue before the last is through.
// A two-entry queue lets a new item be taken while another is in the table.
// After reset a clearing pass over all TABLE_ENTRIES entries (1024 by default) marks
// every entry invalid; busy stays high during it. Both registers return to 4.
// The csr_ port writes fetch_width (index 0) and inst_bytes (index 1); it must be
// written only while the block is idle, which the block itself does not enforce.
module bimodal_branch_predictor_btb_top
   import bbp_pkg::*;
#(
   parameter int TABLE_ENTRIES = BBP_TABLE_ENTRIES,
   parameter int PC_WIDTH      = BBP_PC_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_cmd,
   input  logic [PC_WIDTH-1:0]    req_pkt_pc,
   input  logic [SLOT_W-1:0]      req_resolved_slot,
   input  logic                   req_was_taken,
   input  logic [PC_WIDTH-1:0]    req_resolved_target,
   output logic                   rsp_strobe,
   output logic [PC_WIDTH-1:0]    rsp_next_pc,
   output logic [SLOT_W-1:0]      rsp_pred_slot,
   output logic                   rsp_hit,
   output logic                   rsp_update_miss,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [FW_W-1:0]       fetch_width_ff;
   logic [IB_W-1:0]       inst_bytes_ff;
   bbp_back_stat_type     stat;
   logic                  q_valid;
   logic [2*PC_WIDTH+6:0] q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         fetch_width_ff <= FETCH_WIDTH_RST;
         inst_bytes_ff  <= INST_BYTES_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FETCH_WIDTH: begin
               fetch_width_ff <= csr_wdata[FW_W-1:0];
            end
            CSR_INST_BYTES: begin
               inst_bytes_ff <= csr_wdata[IB_W-1:0];
            end
            default: begin
               fetch_width_ff <= fetch_width_ff;
            end
         endcase
      end
   end

   bbp_front #(
      .PC_WIDTH (PC_WIDTH)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cmd             (req_cmd),
      .req_pkt_pc          (req_pkt_pc),
      .req_resolved_slot   (req_resolved_slot),
      .req_was_taken       (req_was_taken),
      .req_resolved_target (req_resolved_target),
      .stat                (stat),
      .q_valid             (q_valid),
      .q_item              (q_item)
   );

   bbp_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .PC_WIDTH      (PC_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .stat            (stat),
      .fetch_width     (fetch_width_ff),
      .inst_bytes      (inst_bytes_ff),
      .rsp_strobe      (rsp_strobe),
      .rsp_next_pc     (rsp_next_pc),
      .rsp_pred_slot   (rsp_pred_slot),
      .rsp_hit         (rsp_hit),
      .rsp_update_miss (rsp_update_miss)
   );

endmodule

// ===== rtl/core/bbp_checker.sv =====
// Port-level checks of the branch predictor top level, bound to it.
module bbp_checker
   import bbp_pkg::*;
#(
   parameter int PC_WIDTH = BBP_PC_WIDTH
) (
   input logic                clock,
   input logic                reset,
   input logic                busy,
   input logic                rsp_strobe,
   input logic [PC_WIDTH-1:0] rsp_next_pc,
   input logic [SLOT_W-1:0]   rsp_pred_slot,
   input logic                rsp_hit,
   input logic                rsp_update_miss
);

   // The table serves one item at a time, so results never come in adjacent cycles.
   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results in adjacent cycles");

   a_update_miss_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_update_miss) |-> (!rsp_hit && rsp_next_pc == '0 &&
                                           rsp_pred_slot == '0))
      else $error("update miss with non-zero fields or hit");

   // The clearing pass follows every reset, so the block reports busy.
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("not busy after reset");

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe after reset");

endmodule

bind bimodal_branch_predictor_btb_top bbp_checker #(
   .PC_WIDTH (PC_WIDTH)
) u_bbp_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_next_pc     (rsp_next_pc),
   .rsp_pred_slot   (rsp_pred_slot),
   .rsp_hit         (rsp_hit),
   .rsp_update_miss (rsp_update_miss)
);
